/* sv/byte_buffer_bit_field_access_top_defines.svh */
// Assertion macros for the byte buffer bit field access block.
`ifndef BYTE_BUFFER_BIT_FIELD_ACCESS_TOP_DEFINES_SVH
`define BYTE_BUFFER_BIT_FIELD_ACCESS_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BBFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bbfa assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define BBFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbfa assertion failed");

`endif

/* sv/bbfa_pkg.sv */
// Package: widths, constants and state type of the bit field access block.
`timescale 1ns / 1ps
package bbfa_pkg;

  localparam int STORE_BYTES_DEF = 64;
  localparam int OP_W            = 1;
  localparam int BYTE_IDX_W      = 6;
  localparam int BIT_IDX_W       = 3;
  localparam int LEN_W           = 7;
  localparam int VALUE_W         = 64;
  localparam int WIN_W           = 72;
  localparam int CNT_W           = 4;
  localparam int END_W           = 10;
  localparam int MAX_FIELD_BITS  = 64;
  localparam logic [7:0] BYTE_MASK = 8'h0ff;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MERGE,
    ST_DONE
  } state_e;

endpackage

/* sv/bbfa_if.sv */
// Valid/ready channel interfaces for request and result beats.
`timescale 1ns / 1ps
interface bbfa_in_if import bbfa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       operation;
  logic [BYTE_IDX_W-1:0] byte_index;
  logic [BIT_IDX_W-1:0]  bit_index;
  logic [LEN_W-1:0]      length_bits;
  logic [VALUE_W-1:0]    field_value;

  modport source (output valid, operation, byte_index, bit_index, length_bits, field_value,
                  input ready);
  modport sink (input valid, operation, byte_index, bit_index, length_bits, field_value,
                output ready);
endinterface

interface bbfa_out_if import bbfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] read_value;
  logic               range_error;

  modport source (output valid, read_value, range_error, input ready);
  modport sink (input valid, read_value, range_error, output ready);
endinterface

/* sv/byte_buffer_bit_field_access_top.sv */
// Byte store with MSB-first bit field insert and extract, one byte per step.
// Each byte that a field touches (n = 1..9) takes a read step and then a merge step, and the
// result beat is loaded in ST_DONE; zero-length and refused accesses go straight to ST_DONE.
// A new request is taken only in ST_IDLE, so not before the result beat of the last one has
// been loaded into the output register.
// Reset: asynchronous, active low; a clearing pass then zeroes all STORE_BYTES bytes of the
// store, one byte per cycle, with in_i.ready low.
`timescale 1ns / 1ps
`include "byte_buffer_bit_field_access_top_defines.svh"
module byte_buffer_bit_field_access_top import bbfa_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbfa_in_if.sink    in_i,
  bbfa_out_if.source out_o
);

  localparam int AW   = $clog2(STORE_BYTES);
  localparam int CAPW = $clog2(STORE_BYTES * 8 + 1);
  localparam int CW   = (CAPW > END_W) ? CAPW : END_W;

  state_e state_q, state_d;

  logic [7:0]         mem_q [STORE_BYTES];
  logic [7:0]         rdata_q;
  logic [AW-1:0]      addr_q, clr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               op_q;
  logic [2:0]         trail_q;
  logic [WIN_W-1:0]   data_q, m_q;
  logic [VALUE_W-1:0] res_value_q, out_value_q;
  logic               res_err_q, out_err_q, out_valid_q;

  logic               accept, load_out, mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;

  // request decode
  logic [CW-1:0]      field_end;
  logic               req_err, req_empty;
  logic [7:0]         span;
  logic [CNT_W-1:0]   req_n;
  logic [2:0]         req_trail;
  logic [VALUE_W-1:0] req_mask;
  logic [AW-1:0]      req_base;

  // shared merge unit
  logic [7:0]         mb, wbyte;
  logic [WIN_W-1:0]   acc_next;
  logic [VALUE_W-1:0] rd_res;
  logic               last_step;

  assign accept = in_i.valid && in_i.ready;

  assign field_end = CW'({in_i.byte_index, in_i.bit_index}) + CW'(in_i.length_bits);
  assign req_empty = (in_i.length_bits == '0);
  assign req_err   = !req_empty && ((in_i.length_bits > LEN_W'(MAX_FIELD_BITS)) ||
                                    (field_end > CW'(STORE_BYTES * 8)));
  assign span      = 8'(in_i.bit_index) + 8'(in_i.length_bits);
  assign req_n     = CNT_W'((span + 8'd7) >> 3);
  assign req_trail = 3'(8'd0 - span);
  assign req_mask  = ~({VALUE_W{1'b1}} << in_i.length_bits);
  assign req_base  = AW'(in_i.byte_index);

  assign mb        = m_q[7:0] & BYTE_MASK;
  assign wbyte     = (rdata_q & ~mb) | (data_q[7:0] & mb);
  assign acc_next  = {data_q[WIN_W-9:0], rdata_q};
  assign rd_res    = VALUE_W'((acc_next & m_q) >> trail_q);
  assign last_step = (cnt_q == CNT_W'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == AW'(STORE_BYTES - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) state_d = (req_empty || req_err) ? ST_DONE : ST_READ;
      end
      ST_READ:  state_d = ST_MERGE;
      ST_MERGE: state_d = last_step ? ST_DONE : ST_READ;
      ST_DONE:  if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = wbyte;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      ST_IDLE:  in_i.ready = 1'b1;
      ST_MERGE: mem_we = (op_q == OP_WRITE);
      ST_DONE:  load_out = !out_valid_q || out_o.ready;
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      addr_q      <= '0;
      cnt_q       <= '0;
      op_q        <= OP_WRITE;
      trail_q     <= '0;
      res_value_q <= '0;
      res_err_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (accept) begin
        op_q        <= in_i.operation;
        cnt_q       <= req_n;
        trail_q     <= req_trail;
        addr_q      <= (in_i.operation == OP_READ) ? req_base
                                                   : req_base + AW'(req_n) - AW'(1);
        res_value_q <= '0;
        res_err_q   <= req_err;
      end else if (state_q == ST_MERGE) begin
        cnt_q  <= cnt_q - CNT_W'(1);
        addr_q <= (op_q == OP_READ) ? addr_q + AW'(1) : addr_q - AW'(1);
        if (op_q == OP_READ && last_step) res_value_q <= rd_res;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        out_value_q <= res_value_q;
        out_err_q   <= res_err_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // window registers: write data/mask shift down from the last byte, read data shifts in
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= (in_i.operation == OP_READ) ? '0
                : WIN_W'(in_i.field_value & req_mask) << req_trail;
      m_q    <= WIN_W'(req_mask) << req_trail;
    end else if (state_q == ST_MERGE) begin
      if (op_q == OP_READ) begin
        data_q <= acc_next;
      end else begin
        data_q <= data_q >> 8;
        m_q    <= m_q >> 8;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_value  = out_value_q;
  assign out_o.range_error = out_err_q;

  `BBFA_ASSERT_NEXT(a_empty_skips_store, accept && req_empty, state_q == ST_DONE)
  `BBFA_ASSERT_NOW(a_cnt_live, state_q == ST_READ || state_q == ST_MERGE, cnt_q != '0)
  `BBFA_ASSERT_NOW(a_we_only_clear_or_write, mem_we, state_q == ST_CLEAR || (state_q == ST_MERGE && op_q == OP_WRITE))
  `BBFA_ASSERT_NOW(a_err_reads_zero, out_o.valid && out_o.range_error, out_o.read_value == '0)

endmodule

/* tb/sv/bbfa_field_checker.sv */
// Checker: watches both channels, predicts each result beat and compares it.
`timescale 1ns / 1ps
module bbfa_field_checker import bbfa_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbfa_in_if         in_mon,
  bbfa_out_if        out_mon,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o,
  output int         refused_o,
  output int         nonzero_reads_o
);

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               range_error;
  } field_result_t;

  logic [7:0]    field_store [STORE_BYTES];
  field_result_t expected_q [$];
  field_result_t exp_r;
  int            fail_count    = 0;
  int            checked       = 0;
  int            refused       = 0;
  int            nonzero_reads = 0;

  // Bit-serial insert/extract over the shadow store, MSB-first.
  function automatic field_result_t apply_field_access(
    input logic [OP_W-1:0]       op,
    input logic [BYTE_IDX_W-1:0] byte_idx,
    input logic [BIT_IDX_W-1:0]  bit_idx,
    input logic [LEN_W-1:0]      len,
    input logic [VALUE_W-1:0]    value
  );
    field_result_t res;
    int unsigned   start;
    int unsigned   pos;
    int unsigned   i;
    logic [VALUE_W-1:0] acc;
    res   = '0;
    acc   = '0;
    start = int'(byte_idx) * 8 + int'(bit_idx);
    if (len == 0) return res;
    if (int'(len) > MAX_FIELD_BITS || start + int'(len) > STORE_BYTES * 8) begin
      res.range_error = 1'b1;
      return res;
    end
    for (i = 0; i < int'(len); i++) begin
      pos = start + i;
      if (op == OP_WRITE) begin
        field_store[pos >> 3][7 - (pos & 7)] = value[int'(len) - 1 - i];
      end else begin
        acc = {acc[VALUE_W-2:0], field_store[pos >> 3][7 - (pos & 7)]};
      end
    end
    if (op == OP_READ) res.read_value = acc;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STORE_BYTES; k++) field_store[k] = 8'h00;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no request pending: read_value=%h range_error=%b",
                 out_mon.read_value, out_mon.range_error);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          checked++;
          if (out_mon.read_value !== exp_r.read_value) begin
            $error("read_value mismatch: expected %h, actual %h",
                   exp_r.read_value, out_mon.read_value);
            fail_count++;
          end
          if (out_mon.range_error !== exp_r.range_error) begin
            $error("range_error mismatch: expected %b, actual %b",
                   exp_r.range_error, out_mon.range_error);
            fail_count++;
          end
          if (exp_r.range_error) refused++;
          if (exp_r.read_value != '0) nonzero_reads++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.insert(expected_q.size(),
                          apply_field_access(in_mon.operation, in_mon.byte_index,
                                             in_mon.bit_index, in_mon.length_bits,
                                             in_mon.field_value));
      end
    end
  end

  assign fail_count_o    = fail_count;
  assign pending_o       = expected_q.size();
  assign checked_o       = checked;
  assign refused_o       = refused;
  assign nonzero_reads_o = nonzero_reads;

endmodule

/* tb/sv/byte_buffer_bit_field_access_top_tb.sv */
// Testbench top: clock, reset, request and result drivers, and the verdict.
`timescale 1ns / 1ps
module byte_buffer_bit_field_access_top_tb;
  import bbfa_pkg::*;

  localparam int RANDOM_BEATS = 450;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int SETTLE       = 40;
  localparam int STORE_BITS   = STORE_BYTES_DEF * 8;

  logic clk_i;
  logic rst_ni;
  logic quiet;
  logic hold_request;
  int   cycle_cnt;
  int   fail_count;
  int   pending;
  int   checked;
  int   refused;
  int   nonzero_reads;

  bbfa_in_if  in_if ();
  bbfa_out_if out_if ();

  byte_buffer_bit_field_access_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bbfa_field_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_if),
    .out_mon         (out_if),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .refused_o       (refused),
    .nonzero_reads_o (nonzero_reads)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic logic [VALUE_W-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  task automatic send_beat(input logic [OP_W-1:0] op, input int byte_idx, input int bit_idx,
                           input int len, input logic [VALUE_W-1:0] value);
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.byte_index  <= BYTE_IDX_W'(byte_idx);
    in_if.bit_index   <= BIT_IDX_W'(bit_idx);
    in_if.length_bits <= LEN_W'(len);
    in_if.field_value <= value;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (!quiet && $urandom_range(99) < 22) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // in-range access; len 1..64 placed so the field fits the store
  task automatic send_in_range(input logic [OP_W-1:0] op, output int start, output int len);
    len   = ($urandom_range(99) < 15) ? MAX_FIELD_BITS : $urandom_range(1, MAX_FIELD_BITS);
    start = $urandom_range(0, STORE_BITS - len);
    send_beat(op, start >> 3, start & 7, len, rand_value());
  endtask

  // result side
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        for (int h = 0; h < HOLD_CYCLES; h++) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= quiet || ($urandom_range(99) >= 22);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[byte_buffer_bit_field_access_top] ERROR");
    $finish;
  end

  initial begin
    int kind;
    int start;
    int len;
    int last_start;
    int last_len;
    rst_ni            = 1'b0;
    quiet             = 1'b0;
    hold_request      = 1'b0;
    last_start        = 0;
    last_len          = 8;
    in_if.valid       <= 1'b0;
    in_if.operation   <= OP_WRITE;
    in_if.byte_index  <= '0;
    in_if.bit_index   <= '0;
    in_if.length_bits <= '0;
    in_if.field_value <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_beat(OP_WRITE, 0, 0, 64, '1);
    send_beat(OP_READ, 0, 0, 64, '0);
    send_beat(OP_WRITE, 0, 4, 8, '0);
    send_beat(OP_READ, 0, 0, 16, '1);
    send_beat(OP_WRITE, 55, 0, 64, 64'hA5A5_5A5A_0123_4567);
    send_beat(OP_READ, 55, 0, 64, '0);
    send_beat(OP_WRITE, 55, 1, 64, '1);
    send_beat(OP_READ, 63, 1, 64, '0);
    send_beat(OP_WRITE, 63, 7, 1, '1);
    send_beat(OP_READ, 63, 7, 1, '0);
    send_beat(OP_READ, 63, 0, 8, '0);
    send_beat(OP_WRITE, 63, 7, 0, '0);
    send_beat(OP_READ, 63, 7, 0, '1);
    send_beat(OP_WRITE, 0, 0, 127, '1);
    send_beat(OP_READ, 0, 0, 65, '0);
    send_beat(OP_WRITE, 10, 7, 64, 64'hDEAD_BEEF_CAFE_F00D);
    send_beat(OP_READ, 10, 7, 64, '0);
    send_beat(OP_READ, 11, 0, 32, '0);
    send_beat(OP_WRITE, 20, 3, 3, 64'hFFFF_FFFF_FFFF_FFFA);
    send_beat(OP_READ, 20, 0, 8, '0);
    send_beat(OP_WRITE, 30, 5, 17, '0);
    send_beat(OP_READ, 63, 0, 9, '0);
    send_beat(OP_READ, 62, 0, 16, '0);
    send_beat(OP_WRITE, 40, 2, 64, '1);
    send_beat(OP_READ, 40, 0, 64, '0);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 150) hold_request = 1'b1;
      if (n == 200) quiet = 1'b1;
      if (n == 280) quiet = 1'b0;
      if (n == 330) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      kind = $urandom_range(99);
      if (kind < 45) begin
        send_in_range(OP_WRITE, last_start, last_len);
      end else if (kind < 80) begin
        if ($urandom_range(1) == 1) begin
          send_beat(OP_READ, last_start >> 3, last_start & 7, last_len, rand_value());
        end else begin
          send_in_range(OP_READ, start, len);
        end
      end else if (kind < 88) begin
        send_beat(OP_W'($urandom_range(1)), $urandom_range(63), $urandom_range(7), 0,
                  rand_value());
      end else if (kind < 94) begin
        send_beat(OP_W'($urandom_range(1)), $urandom_range(63), $urandom_range(7),
                  $urandom_range(MAX_FIELD_BITS + 1, 127), rand_value());
      end else begin
        len   = $urandom_range(2, MAX_FIELD_BITS);
        start = $urandom_range(STORE_BITS - len + 1, STORE_BITS - 1);
        send_beat(OP_W'($urandom_range(1)), start >> 3, start & 7, len, rand_value());
      end
    end
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("run covered %0d result beats: %0d refused accesses, %0d nonzero read fields",
             checked, refused, nonzero_reads);
    $display("including full-width, zero-length, store-end and long receiver stall cases");
    if (fail_count == 0 && pending == 0) begin
      $display("[byte_buffer_bit_field_access_top] OK");
    end else begin
      $display("[byte_buffer_bit_field_access_top] ERROR");
    end
    $finish;
  end

endmodule
